/* rtl/core/telemetry_frame_builder_crc32_defines.svh */
// assertion macros for the telemetry frame builder
// included by the top level; no other dependencies
`ifndef TELEMETRY_FRAME_BUILDER_CRC32_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_CRC32_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define TFB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define TFB_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TFB_ASSERT(lbl, clk, rst, prop)
`define TFB_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

/* rtl/core/tfb_pkg.sv */
// shared types, constants and the crc-32 byte step for the frame builder
// no dependencies
package tfb_pkg;

  localparam int SEQ_W      = 24;
  localparam int VAL_W      = 16;
  localparam int LAP_W      = 10;
  localparam int IN_DATA_W  = 88;
  localparam int SPAN_W     = 5;
  localparam int IDX_W      = 5;
  localparam int QUOT_W     = 15;

  localparam logic [7:0] HDR0     = 8'hAA;
  localparam logic [7:0] HDR1     = 8'h55;
  localparam logic [7:0] LEN_BYTE = 8'd10;

  localparam int LAP_MOD = 1000;
  // ceil(2^34 / 1000): exact quotient for every 24-bit sequence number
  localparam logic [24:0] RECIP       = 25'd17179870;
  localparam int          RECIP_SHIFT = 34;

  localparam logic [IDX_W-1:0] BODY_BYTES = 5'd16;
  localparam logic [IDX_W-1:0] LAST_IDX   = 5'd19;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 5'd14;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LAP_W-1:0] lap;
    logic [VAL_W-1:0] distance;
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] steering;
    logic [VAL_W-1:0] throttle;
  } record_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic [31:0]      crc;
  } back_status_t;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/telemetry_frame_builder_crc32.sv */
// top level of the telemetry frame builder with reflected crc-32 trailer
// depends on tfb_pkg, tfb_front, tfb_queue, tfb_back and the defines header
//
//  channel   dir  signals                      meaning
//  --------  ---  ---------------------------  --------------------------------
//  slave     in   s_tvalid s_tready s_tdata    one telemetry record
//  master    out  m_tvalid m_tready m_tdata    one frame byte, m_tlast on byte 19
//                 m_tlast
//  config    in   cfg_valid cfg_ready cfg_data crc span register
//
// each record turns into 20 bytes; the byte serializer emits one byte per
// cycle while m_tready is high and pops a record only with its last byte
// record path: front end s1, s2, queue, then the output register
// rst is synchronous: queue and pipeline empty, crc span back to 14
// a stall on the master side holds the output register; the slave side keeps
// taking records until the two-stage front end and the queue fill up
`include "telemetry_frame_builder_crc32_defines.svh"

module telemetry_frame_builder_crc32 (
  input  logic                              clk,
  input  logic                              rst,
  // slave record stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // seq_number[23:0], distance_value[39:24], speed_value[55:40],
  // steering_value[71:56], throttle_value[87:72]
  input  logic [tfb_pkg::IN_DATA_W-1:0]     s_tdata,
  // master byte stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_byte[7:0]
  output logic [7:0]                        m_tdata,
  // last_byte
  output logic                              m_tlast,
  // crc span register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tfb_pkg::SPAN_W-1:0]        cfg_data
);

  logic [tfb_pkg::SPAN_W-1:0] crc_span;

  // front end to queue
  logic                  fr_valid;
  logic                  fr_ready;
  tfb_pkg::record_t      fr_rec;

  // queue to back end
  logic                  head_valid;
  logic                  head_pop;
  tfb_pkg::record_t      head_rec;

  tfb_pkg::q_status_t    q_st;
  tfb_pkg::back_status_t bk_st;

  // first byte of a frame going into the output register
  logic                  frame_start;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_span <= tfb_pkg::SPAN_RESET;
    end else if (cfg_valid) begin
      crc_span <= cfg_data;
    end
  end

  // lap count: seq mod 1000 by reciprocal multiply, then one back-multiply
  tfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_rec   (fr_rec)
  );

  // decouples the record front end from the byte serializer
  tfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .in_rec     (fr_rec),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_rec   (head_rec),
    .status     (q_st)
  );

  // serializer works straight off the queue head and pops it on the last byte
  tfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (head_pop),
    .crc_span   (crc_span),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .status     (bk_st)
  );

  assign frame_start = bk_st.load && (bk_st.idx == '0);

  // lap count leaving the front end is always a proper remainder
  `TFB_ASSERT(a_lap_range, clk, rst, fr_valid |-> (fr_rec.lap < 10'd1000))
  // every frame starts its crc from all ones
  `TFB_ASSERT(a_crc_seed, clk, rst, frame_start |-> (bk_st.crc == tfb_pkg::CRC_INIT))
  // the first byte of a frame lands in the output register as the sync byte
  `TFB_ASSERT(a_sync_byte, clk, rst, frame_start |=> (m_tdata == tfb_pkg::HDR0))
  // the queue is never popped while empty
  `TFB_ASSERT_NEVER(a_pop_empty, clk, rst, q_st.pop && q_st.empty)

endmodule

/* rtl/core/tfb_front.sv */
// front end: accepts records and works out the lap count over two stages
// depends on tfb_pkg
module tfb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tfb_pkg::IN_DATA_W-1:0]   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tfb_pkg::record_t                out_rec
);

  logic                         s1_valid;
  tfb_pkg::record_t             s1_rec;
  logic [tfb_pkg::QUOT_W-1:0]   s1_quot;
  logic                         s2_valid;
  tfb_pkg::record_t             s2_rec;
  logic                         s1_en;
  logic                         s2_en;
  tfb_pkg::record_t             in_rec;
  tfb_pkg::record_t             s1_done;
  logic [48:0]                  prod;
  logic [23:0]                  quot_x;
  logic [23:0]                  rem;

  assign s2_en    = !s2_valid || out_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  always_comb begin
    in_rec          = '0;
    in_rec.seq      = in_data[23:0];
    in_rec.distance = in_data[39:24];
    in_rec.speed    = in_data[55:40];
    in_rec.steering = in_data[71:56];
    in_rec.throttle = in_data[87:72];
  end

  // quotient by reciprocal multiply
  assign prod   = {25'd0, in_data[23:0]} * {24'd0, tfb_pkg::RECIP};
  // quotient times 1000, then the remainder
  assign quot_x = {9'd0, s1_quot} * 24'd1000;
  assign rem    = s1_rec.seq - quot_x;

  // stage one record with its lap count filled in
  always_comb begin
    s1_done     = s1_rec;
    s1_done.lap = rem[tfb_pkg::LAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= in_valid;
      if (s2_en) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_rec  <= in_rec;
      s1_quot <= prod[48:tfb_pkg::RECIP_SHIFT];
    end
    if (s2_en && s1_valid) begin
      s2_rec <= s1_done;
    end
  end

  assign out_valid = s2_valid;
  assign out_rec   = s2_rec;

endmodule

/* rtl/core/tfb_queue.sv */
// two-entry record queue between front and back ends
// depends on tfb_pkg
module tfb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tfb_pkg::record_t     in_rec,
  output logic                 head_valid,
  input  logic                 pop,
  output tfb_pkg::record_t     head_rec,
  output tfb_pkg::q_status_t   status
);

  tfb_pkg::record_t              mem [tfb_pkg::QDEPTH];
  logic [tfb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tfb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tfb_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          full;
  logic                          empty;

  assign full       = (count == tfb_pkg::QCNT_W'(tfb_pkg::QDEPTH));
  assign empty      = (count == '0);
  assign in_ready   = !full;
  assign push       = in_valid && !full;
  assign head_valid = !empty;
  assign head_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_rec;
  end

  always_comb begin
    status.push  = push;
    status.pop   = pop;
    status.empty = empty;
    status.full  = full;
  end

endmodule

/* rtl/core/tfb_back.sv */
// back end: one frame a byte per cycle when not stalled, folds in the crc-32
// depends on tfb_pkg
module tfb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  tfb_pkg::record_t            head_rec,
  output logic                        pop,
  input  logic [tfb_pkg::SPAN_W-1:0]  crc_span,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output tfb_pkg::back_status_t       status
);

  logic [tfb_pkg::IDX_W-1:0] idx;
  logic [31:0]               crc;
  logic [31:0]               crc_upd;
  logic [31:0]               crc_fin;
  logic [15:0]               lap_word;
  logic [7:0]                byte_sel;
  logic                      load;
  logic                      at_last;
  logic                      covered;

  assign load     = head_valid && (!out_valid || out_ready);
  assign at_last  = (idx == tfb_pkg::LAST_IDX);
  assign pop      = load && at_last;
  assign crc_upd  = tfb_pkg::crc32_byte(crc, byte_sel);
  assign crc_fin  = ~crc;
  assign lap_word = {6'd0, head_rec.lap};
  // spans above sixteen saturate since only body bytes reach this test
  assign covered  = (idx < tfb_pkg::BODY_BYTES) && ({1'b0, idx} < {1'b0, crc_span});

  always_comb begin
    case (idx)
      5'd0:    byte_sel = tfb_pkg::HDR0;
      5'd1:    byte_sel = tfb_pkg::HDR1;
      5'd2:    byte_sel = head_rec.seq[7:0];
      5'd3:    byte_sel = head_rec.seq[15:8];
      5'd4:    byte_sel = head_rec.seq[23:16];
      5'd5:    byte_sel = tfb_pkg::LEN_BYTE;
      5'd6:    byte_sel = lap_word[7:0];
      5'd7:    byte_sel = lap_word[15:8];
      5'd8:    byte_sel = head_rec.distance[7:0];
      5'd9:    byte_sel = head_rec.distance[15:8];
      5'd10:   byte_sel = head_rec.speed[7:0];
      5'd11:   byte_sel = head_rec.speed[15:8];
      5'd12:   byte_sel = head_rec.steering[7:0];
      5'd13:   byte_sel = head_rec.steering[15:8];
      5'd14:   byte_sel = head_rec.throttle[7:0];
      5'd15:   byte_sel = head_rec.throttle[15:8];
      5'd16:   byte_sel = crc_fin[7:0];
      5'd17:   byte_sel = crc_fin[15:8];
      5'd18:   byte_sel = crc_fin[23:16];
      5'd19:   byte_sel = crc_fin[31:24];
      default: byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= tfb_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
        if (at_last)      crc <= tfb_pkg::CRC_INIT;
        else if (covered) crc <= crc_upd;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_sel;
      out_last <= at_last;
    end
  end

  always_comb begin
    status.load = load;
    status.idx  = idx;
    status.crc  = crc;
  end

endmodule
